// ----- rtl/conductor_fresnel_reflectance_unit_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef CONDUCTOR_FRESNEL_REFLECTANCE_UNIT_MACROS_SVH
`define CONDUCTOR_FRESNEL_REFLECTANCE_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define CFR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define CFR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define CFR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CFR_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/cfr_pkg.sv -----
package cfr_pkg;

	localparam int CHANNELS  = 3;
	localparam int FIELD_W   = 16;
	localparam int IN_W      = FIELD_W * (1 + 2 * CHANNELS);
	localparam int OUT_W     = FIELD_W * CHANNELS;
	localparam logic [FIELD_W-1:0] ONE_Q15 = 16'd32768;

	// square root: one result bit per stage
	localparam int SQ_STEPS  = 30;
	localparam int SQ_IN_W   = 2 * SQ_STEPS;
	localparam int SQ_REM_W  = SQ_STEPS + 4;

	// ratio: one quotient bit per stage, quotient is at most 2^30
	localparam int DIV_W     = 32;
	localparam int DIV_STEPS = 31;

	localparam int LANE_LAT  = 3 + SQ_STEPS + 1 + SQ_STEPS + 3 + DIV_STEPS + 1;
	localparam int PIPE_LAT  = LANE_LAT + 1;

endpackage

// ----- rtl/cfr_sqrt.sv -----
module cfr_sqrt (
	input  logic                         clk,
	input  logic                         en,
	input  logic [cfr_pkg::SQ_IN_W-1:0]  radicand,
	output logic [cfr_pkg::SQ_STEPS-1:0] root
);
	import cfr_pkg::*;

	logic [SQ_IN_W-1:0]  rad_s  [SQ_STEPS];
	logic [SQ_REM_W-1:0] rem_s  [SQ_STEPS];
	logic [SQ_STEPS-1:0] root_s [SQ_STEPS];

	for (genvar st = 0; st < SQ_STEPS; st++) begin : g_stage
		logic [SQ_IN_W-1:0]  rad_in;
		logic [SQ_REM_W-1:0] rem_in, rem_sh, trial;
		logic [SQ_STEPS-1:0] root_in;
		logic                ge;

		if (st == 0) begin : g_first
			assign rad_in  = radicand;
			assign rem_in  = '0;
			assign root_in = '0;
		end else begin : g_next
			assign rad_in  = rad_s[st-1];
			assign rem_in  = rem_s[st-1];
			assign root_in = root_s[st-1];
		end

		// bring down the next pair of radicand bits
		assign rem_sh = {rem_in[SQ_REM_W-3:0], rad_in[2*(SQ_STEPS-1-st)+1 -: 2]};
		assign trial  = SQ_REM_W'({root_in, 2'b01});
		assign ge     = (rem_sh >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[st]  <= rad_in;
				rem_s[st]  <= ge ? (rem_sh - trial) : rem_sh;
				root_s[st] <= {root_in[SQ_STEPS-2:0], ge};
			end
		end
	end

	assign root = root_s[SQ_STEPS-1];

endmodule

// ----- rtl/cfr_div.sv -----
module cfr_div (
	input  logic                          clk,
	input  logic                          en,
	input  logic [cfr_pkg::DIV_W-1:0]     num,
	input  logic [cfr_pkg::DIV_W-1:0]     den,
	output logic [cfr_pkg::DIV_STEPS-1:0] quo
);
	import cfr_pkg::*;

	logic [DIV_W-1:0]     rem_s [DIV_STEPS];
	logic [DIV_W-1:0]     den_s [DIV_STEPS];
	logic [DIV_STEPS-1:0] quo_s [DIV_STEPS];

	for (genvar st = 0; st < DIV_STEPS; st++) begin : g_stage
		logic [DIV_W:0]       cand;
		logic [DIV_W-1:0]     den_in;
		logic [DIV_STEPS-1:0] quo_in;
		logic                 ge;

		if (st == 0) begin : g_first
			// numerator never exceeds the denominator
			assign cand   = {1'b0, num};
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign cand   = {rem_s[st-1], 1'b0};
			assign den_in = den_s[st-1];
			assign quo_in = quo_s[st-1];
		end

		assign ge = (cand >= {1'b0, den_in});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[st] <= ge ? DIV_W'(cand - {1'b0, den_in}) : DIV_W'(cand);
				den_s[st] <= den_in;
				quo_s[st] <= {quo_in[DIV_STEPS-2:0], ge};
			end
		end
	end

	assign quo = quo_s[DIV_STEPS-1];

endmodule

// ----- rtl/cfr_lane.sv -----
module cfr_lane (
	input  logic                        clk,
	input  logic                        en,
	input  logic [cfr_pkg::FIELD_W-1:0] cos_incident,
	input  logic [cfr_pkg::FIELD_W-1:0] eta,
	input  logic [cfr_pkg::FIELD_W-1:0] absorb,
	output logic [cfr_pkg::FIELD_W-1:0] refl
);
	import cfr_pkg::*;

	// stage 1: squares
	logic [15:0] cc;
	logic [15:0] c_s1;
	logic [20:0] c2_s1;
	logic [27:0] e2_s1, k2_s1;

	assign cc = (cos_incident > ONE_Q15) ? ONE_Q15 : cos_incident;

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1  <= cc;
			c2_s1 <= 21'((32'(cc) * 32'(cc)) >> 10);
			e2_s1 <= 28'((32'(eta) * 32'(eta)) >> 4);
			k2_s1 <= 28'((32'(absorb) * 32'(absorb)) >> 4);
		end
	end

	// stage 2: sine squared, t1, e2*k2
	logic [20:0]        s2_w;
	logic [15:0]        c_s2;
	logic [20:0]        c2_s2, s2_s2;
	logic signed [30:0] t1_s2;
	logic [55:0]        ek_s2;

	assign s2_w = 21'(21'h100000 - c2_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			c_s2  <= c_s1;
			c2_s2 <= c2_s1;
			s2_s2 <= s2_w;
			t1_s2 <= $signed({3'b0, e2_s1}) - $signed({3'b0, k2_s1}) - $signed({10'b0, s2_w});
			ek_s2 <= 56'(e2_s1) * 56'(k2_s1);
		end
	end

	// stage 3: radicand of A, sine to the fourth
	logic [28:0]        mag;
	logic [57:0]        msq;
	logic [59:0]        rad_s3;
	logic [15:0]        c_s3;
	logic [20:0]        c2_s3, s2_s3, s4_s3;
	logic signed [30:0] t1_s3;
	logic [41:0]        s2sq;

	assign mag  = t1_s2[30] ? 29'(-t1_s2) : 29'(t1_s2);
	assign msq  = mag * mag;
	assign s2sq = 42'(s2_s2) * 42'(s2_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s3 <= 60'(msq) + 60'({ek_s2, 2'b00});
			s4_s3  <= 21'(s2sq >> 20);
			c_s3   <= c_s2;
			c2_s3  <= c2_s2;
			s2_s3  <= s2_s2;
			t1_s3  <= t1_s2;
		end
	end

	// A = sqrt(t1^2 + 4 e2 k2)
	logic [SQ_STEPS-1:0] big_a;

	cfr_sqrt u_sqrt_a (
		.clk      (clk),
		.en       (en),
		.radicand (rad_s3),
		.root     (big_a)
	);

	logic [15:0]        c_dq  [SQ_STEPS];
	logic [20:0]        c2_dq [SQ_STEPS];
	logic [20:0]        s2_dq [SQ_STEPS];
	logic [20:0]        s4_dq [SQ_STEPS];
	logic signed [30:0] t1_dq [SQ_STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			c_dq[0]  <= c_s3;
			c2_dq[0] <= c2_s3;
			s2_dq[0] <= s2_s3;
			s4_dq[0] <= s4_s3;
			t1_dq[0] <= t1_s3;
			for (int i = 1; i < SQ_STEPS; i++) begin
				c_dq[i]  <= c_dq[i-1];
				c2_dq[i] <= c2_dq[i-1];
				s2_dq[i] <= s2_dq[i-1];
				s4_dq[i] <= s4_dq[i-1];
				t1_dq[i] <= t1_dq[i-1];
			end
		end
	end

	// stage A: half of (A + t1), term1, term3
	logic signed [31:0] half_sum;
	logic [29:0]        hu;
	logic [50:0]        ac2;
	logic [29:0]        hu_sa;
	logic [30:0]        term1_sa, term3_sa;
	logic [15:0]        c_sa;
	logic [20:0]        s2_sa;

	assign half_sum = $signed({2'b0, big_a}) + 32'(t1_dq[SQ_STEPS-1]);
	assign hu       = (half_sum > 0) ? half_sum[30:1] : '0;
	assign ac2      = 51'(big_a) * 51'(c2_dq[SQ_STEPS-1]);

	always_ff @(posedge clk) begin
		if (en) begin
			hu_sa    <= hu;
			term1_sa <= 31'(big_a) + 31'(c2_dq[SQ_STEPS-1]);
			term3_sa <= 31'(ac2 >> 20) + 31'(s4_dq[SQ_STEPS-1]);
			c_sa     <= c_dq[SQ_STEPS-1];
			s2_sa    <= s2_dq[SQ_STEPS-1];
		end
	end

	// a = sqrt(hu << 20)
	logic [SQ_STEPS-1:0] small_a;

	cfr_sqrt u_sqrt_b (
		.clk      (clk),
		.en       (en),
		.radicand ({10'b0, hu_sa, 20'b0}),
		.root     (small_a)
	);

	logic [30:0] term1_dq [SQ_STEPS];
	logic [30:0] term3_dq [SQ_STEPS];
	logic [15:0] cb_dq    [SQ_STEPS];
	logic [20:0] s2b_dq   [SQ_STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			term1_dq[0] <= term1_sa;
			term3_dq[0] <= term3_sa;
			cb_dq[0]    <= c_sa;
			s2b_dq[0]   <= s2_sa;
			for (int i = 1; i < SQ_STEPS; i++) begin
				term1_dq[i] <= term1_dq[i-1];
				term3_dq[i] <= term3_dq[i-1];
				cb_dq[i]    <= cb_dq[i-1];
				s2b_dq[i]   <= s2b_dq[i-1];
			end
		end
	end

	// stage B: term2 = 2 a cos >> 15
	logic [40:0] acos;
	logic [25:0] term2_sb;
	logic [30:0] term1_sb, term3_sb;
	logic [20:0] s2_sb;

	assign acos = 41'(small_a[24:0]) * 41'(cb_dq[SQ_STEPS-1]);

	always_ff @(posedge clk) begin
		if (en) begin
			term2_sb <= 26'(acos >> 14);
			term1_sb <= term1_dq[SQ_STEPS-1];
			term3_sb <= term3_dq[SQ_STEPS-1];
			s2_sb    <= s2b_dq[SQ_STEPS-1];
		end
	end

	// stage C: term4, numerator and denominator of rs
	logic [46:0] t2s2;
	logic [26:0] term4_sc;
	logic [30:0] term3_sc;
	logic [DIV_W-1:0] n1_sc, d1_sc;

	assign t2s2 = 47'(term2_sb) * 47'(s2_sb);

	always_ff @(posedge clk) begin
		if (en) begin
			term4_sc <= 27'(t2s2 >> 20);
			term3_sc <= term3_sb;
			n1_sc    <= (term1_sb > 31'(term2_sb)) ? DIV_W'(term1_sb - 31'(term2_sb)) : '0;
			d1_sc    <= DIV_W'(term1_sb) + DIV_W'(term2_sb);
		end
	end

	// stage D: numerator and denominator of q, zero-denominator flag
	logic [DIV_W-1:0] d2;
	logic [DIV_W-1:0] n1_sd, d1_sd, n2_sd, d2_sd;
	logic             z_sd;

	assign d2 = DIV_W'(term3_sc) + DIV_W'(term4_sc);

	always_ff @(posedge clk) begin
		if (en) begin
			n1_sd <= n1_sc;
			d1_sd <= d1_sc;
			n2_sd <= (term3_sc > 31'(term4_sc)) ? DIV_W'(term3_sc - 31'(term4_sc)) : '0;
			d2_sd <= d2;
			z_sd  <= (d1_sc == '0) || (d2 == '0);
		end
	end

	logic [DIV_STEPS-1:0] rs, q;

	cfr_div u_div_s (
		.clk (clk),
		.en  (en),
		.num (n1_sd),
		.den (d1_sd),
		.quo (rs)
	);

	cfr_div u_div_p (
		.clk (clk),
		.en  (en),
		.num (n2_sd),
		.den (d2_sd),
		.quo (q)
	);

	logic z_dq [DIV_STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			z_dq[0] <= z_sd;
			for (int i = 1; i < DIV_STEPS; i++) begin
				z_dq[i] <= z_dq[i-1];
			end
		end
	end

	// stage E: rp = rs * q
	logic [61:0]          rsq;
	logic [DIV_STEPS-1:0] rs_se, rp_se;
	logic                 z_se;

	assign rsq = 62'(rs) * 62'(q);

	always_ff @(posedge clk) begin
		if (en) begin
			rs_se <= rs;
			rp_se <= DIV_STEPS'(rsq >> 30);
			z_se  <= z_dq[DIV_STEPS-1];
		end
	end

	// mean of s and p, down to Q1.15, saturate
	logic [31:0] mean;
	logic [15:0] r_q15;

	assign mean  = 32'(rs_se) + 32'(rp_se);
	assign r_q15 = 16'(mean >> 16);
	assign refl  = (z_se || (mean[31:16] > 16'(ONE_Q15))) ? ONE_Q15 : r_q15;

endmodule

// ----- rtl/conductor_fresnel_reflectance_unit.sv -----
// Unpolarized conductor Fresnel reflectance, one lane per color channel.
// A beat carries the incidence cosine (Q1.15, values above 1.0 are taken as
// 1.0) and, per channel, the complex index eta + i*k (unsigned Q4.12). The
// result beat carries the reflectance per channel, Q1.15 in 0..1.0; a channel
// whose denominator is zero reports 1.0. The unit keeps no state and accepts
// one beat every clock cycle unless the output stalls; results appear in
// order. The depth is set by the bit-per-stage pipelines inside each
// lane: two 30-stage square roots and a 31-stage divider pair, plus setup
// multiplies and the output register. Backpressure on the output stalls the
// whole pipeline in place, so s_axis_tready drops only while a result waits.
`include "conductor_fresnel_reflectance_unit_macros.svh"

module conductor_fresnel_reflectance_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	// cos_incident, eta_c0, eta_c1, eta_c2, absorb_c0, absorb_c1, absorb_c2
	input  logic [cfr_pkg::IN_W-1:0]  s_axis_tdata,
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	// refl_c0, refl_c1, refl_c2
	output logic [cfr_pkg::OUT_W-1:0] m_axis_tdata
);
	import cfr_pkg::*;

	logic                en;
	logic [PIPE_LAT-1:0] vld_q;
	logic [OUT_W-1:0]    lane_refl;
	logic [OUT_W-1:0]    tdata_q;

	// advance everything unless a result is held at the output
	assign en            = ~m_axis_tvalid | m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_LAT-2:0], s_axis_tvalid};
		end
	end

	// one lane per channel, all sharing the cosine
	for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
		cfr_lane u_lane (
			.clk          (clk),
			.en           (en),
			.cos_incident (s_axis_tdata[FIELD_W-1:0]),
			.eta          (s_axis_tdata[FIELD_W*(1+ch) +: FIELD_W]),
			.absorb       (s_axis_tdata[FIELD_W*(1+CHANNELS+ch) +: FIELD_W]),
			.refl         (lane_refl[FIELD_W*ch +: FIELD_W])
		);
	end

	// merge: gather lane results into the output beat
	always_ff @(posedge clk) begin
		if (en) begin
			tdata_q <= lane_refl;
		end
	end

	assign m_axis_tvalid = vld_q[PIPE_LAT-1];
	assign m_axis_tdata  = tdata_q;

	`CFR_ASSERT_IMP(a_no_accept_on_stall, clk, arst_n, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
	`CFR_ASSERT_IMP(a_refl0_sat, clk, arst_n, m_axis_tvalid, m_axis_tdata[15:0] <= ONE_Q15)
	`CFR_ASSERT_NXT(a_stall_holds_pipe, clk, arst_n, !en, vld_q == $past(vld_q))

endmodule
